### rtl/core/one_wire_bus_master_assert.svh
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one_wire_bus_master assertion failed");
// antecedent implies consequent in the next cycle
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one_wire_bus_master assertion failed");
`else
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/owm_pkg.sv
// ----------------------------------------------------------------------------
// One-wire bus master package
// Phase codes, command kinds, register indexes and timing defaults.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int COUNT_WIDTH_DEF = 10;
    localparam int CFG_W           = 10;
    localparam int CFG_REGS        = 8;
    localparam int IDX_W           = 3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_GAP   = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HOLD  = 4'd6,
        PH_RD_GAP   = 4'd7,
        PH_RD_REC   = 4'd8,
        PH_RD_LOW   = 4'd9,
        PH_RD_WAIT  = 4'd10,
        PH_RD_TAIL  = 4'd11
    } t_phase;

    typedef logic [1:0]       t_kind;
    typedef logic [IDX_W-1:0] t_reg_idx;
    typedef logic [CFG_W-1:0] t_cfg;

    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_RESET = 2'd1;
    localparam t_kind KIND_WRITE = 2'd2;
    localparam t_kind KIND_READ  = 2'd3;

    localparam t_reg_idx REG_RESET_LOW     = 3'd0;
    localparam t_reg_idx REG_PRESENCE_WAIT = 3'd1;
    localparam t_reg_idx REG_RESET_TAIL    = 3'd2;
    localparam t_reg_idx REG_WRITE_LOW     = 3'd3;
    localparam t_reg_idx REG_WRITE_SLOT    = 3'd4;
    localparam t_reg_idx REG_READ_LOW      = 3'd5;
    localparam t_reg_idx REG_READ_SAMPLE   = 3'd6;
    localparam t_reg_idx REG_READ_TAIL     = 3'd7;

    localparam t_cfg CFG_RESET [CFG_REGS] = '{
        10'd500, 10'd60, 10'd240, 10'd2, 10'd60, 10'd1, 10'd5, 10'd56
    };

    localparam t_cfg WR_GAP_TICKS  = 10'd100;
    localparam t_cfg RD_GAP_TICKS  = 10'd1;
    localparam t_cfg RD_REC_TICKS  = 10'd1;
    localparam t_cfg ONE_TICK      = 10'd1;

endpackage

### rtl/core/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// One-wire bus master
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one beat per microsecond tick,
//    carrying the command kind, the byte to write and the sampled bus level.
//  - Output channel (o_out_valid / i_out_ready): one result beat per input
//    beat, in order: bus drive, busy, done, presence, read byte, reject flag.
//  - Config channel (i_cfg_valid / o_cfg_ready): always ready, writes one
//    timing register per beat; write only while no command is in progress.
//  - A tick's result is registered, valid the cycle after the tick is
//    accepted. One tick per cycle while results are taken, set by the single
//    phase/counter update between the state registers and the result register.
//  - The result register parts the channels: a new tick is taken while the
//    previous result is being taken in the same cycle; if the receiver
//    stalls with a result held, o_in_ready drops until it is taken.
//  - Synchronous reset returns the sequencer to idle, clears presence and the
//    read byte, and loads the default slot timings. No clearing pass.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int COUNT_WIDTH = owm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  owm_pkg::t_kind         i_kind,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_line_level,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_drive_low,
    output logic                   o_busy_res,
    output logic                   o_done_res,
    output logic                   o_presence_ok,
    output logic [7:0]             o_read_data,
    output logic                   o_command_rejected,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  owm_pkg::t_reg_idx      i_cfg_index,
    input  owm_pkg::t_cfg          i_cfg_data
);
    import owm_pkg::*;

    `include "one_wire_bus_master_assert.svh"

    // width used to compare a register value against the counter range
    localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    t_cfg                   r_cfg [CFG_REGS];
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    t_kind                  r_act, n_act;
    logic                   r_pres, n_pres;
    logic [7:0]             r_rres, n_rres;
    logic                   n_fin;

    logic                   r_out_valid;
    logic                   r_drive, r_busy, r_done, r_rej;
    logic                   n_drive, n_busy, n_rej;

    // phase and shift after a possible command start this tick
    t_phase                 s_phase;
    logic [7:0]             s_shift;
    logic                   s_start;

    t_cfg                   len_raw;
    logic [LW-1:0]          len_ext, inc_ext;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        s_start = (r_phase == PH_IDLE) && (i_kind != KIND_TICK);
        s_phase = r_phase;
        s_shift = r_shift;
        if (s_start) begin
            unique case (i_kind)
                KIND_RESET: s_phase = PH_RST_LOW;
                KIND_WRITE: begin
                    s_phase = PH_WR_GAP;
                    s_shift = i_data_byte;
                end
                KIND_READ: begin
                    s_phase = PH_RD_GAP;
                    s_shift = 8'h00;
                end
                default: s_phase = PH_IDLE;
            endcase
        end
    end

    // phase length, zero counts as one tick, saturated at the counter range
    always_comb begin
        unique case (s_phase)
            PH_RST_LOW:  len_raw = r_cfg[REG_RESET_LOW];
            PH_RST_WAIT: len_raw = r_cfg[REG_PRESENCE_WAIT];
            PH_RST_TAIL: len_raw = r_cfg[REG_RESET_TAIL];
            PH_WR_GAP:   len_raw = WR_GAP_TICKS;
            PH_WR_LOW:   len_raw = r_cfg[REG_WRITE_LOW];
            PH_WR_HOLD:  len_raw = r_cfg[REG_WRITE_SLOT];
            PH_RD_GAP:   len_raw = RD_GAP_TICKS;
            PH_RD_REC:   len_raw = RD_REC_TICKS;
            PH_RD_LOW:   len_raw = r_cfg[REG_READ_LOW];
            PH_RD_WAIT:  len_raw = r_cfg[REG_READ_SAMPLE];
            PH_RD_TAIL:  len_raw = r_cfg[REG_READ_TAIL];
            default:     len_raw = ONE_TICK;
        endcase
        len_ext = LW'(len_raw);
        if (len_raw == '0) begin
            len_ext = LW'(ONE_TICK);
        end else if (len_ext > LW'({COUNT_WIDTH{1'b1}})) begin
            len_ext = LW'({COUNT_WIDTH{1'b1}});
        end
        tick_inc = (s_start ? '0 : r_tick) + COUNT_WIDTH'(1);
        inc_ext  = LW'(tick_inc);
    end

    // next state
    always_comb begin
        n_phase = s_phase;
        n_shift = s_shift;
        n_tick  = s_start ? '0 : r_tick;
        n_bit   = s_start ? 4'd0 : r_bit;
        n_act   = s_start ? i_kind : r_act;
        n_pres  = (s_start && (i_kind == KIND_RESET)) ? 1'b0 : r_pres;
        n_rres  = r_rres;
        n_fin   = 1'b0;
        if (s_phase != PH_IDLE) begin
            n_tick = tick_inc;
            if (inc_ext >= len_ext) begin
                n_tick = '0;
                unique case (s_phase)
                    PH_RST_LOW:  n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        n_pres = !i_line_level;
                        if (n_pres && (r_cfg[REG_RESET_TAIL] != '0)) begin
                            n_phase = PH_RST_TAIL;
                        end else begin
                            n_fin = 1'b1;
                        end
                    end
                    PH_WR_GAP:   n_phase = PH_WR_LOW;
                    PH_WR_LOW:   n_phase = PH_WR_HOLD;
                    PH_WR_HOLD: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        n_bit   = n_bit + 4'd1;
                        if (n_bit[3]) begin
                            n_fin = 1'b1;
                        end else begin
                            n_phase = PH_WR_LOW;
                        end
                    end
                    PH_RD_GAP:   n_phase = PH_RD_REC;
                    PH_RD_REC:   n_phase = PH_RD_LOW;
                    PH_RD_LOW:   n_phase = PH_RD_WAIT;
                    PH_RD_WAIT, PH_RD_TAIL: begin
                        if (s_phase == PH_RD_WAIT) begin
                            n_shift = {i_line_level, n_shift[7:1]};
                        end
                        if ((s_phase == PH_RD_WAIT) && (r_cfg[REG_READ_TAIL] != '0)) begin
                            n_phase = PH_RD_TAIL;
                        end else begin
                            n_bit = n_bit + 4'd1;
                            if (n_bit[3]) begin
                                n_rres = n_shift;
                                n_fin  = 1'b1;
                            end else begin
                                n_phase = PH_RD_REC;
                            end
                        end
                    end
                    default: n_fin = 1'b1;   // reset tail end and stray codes
                endcase
                if (n_fin) begin
                    n_phase = PH_IDLE;
                    n_act   = KIND_TICK;
                end
            end
        end
    end

    // per-tick outputs
    always_comb begin
        n_busy = (s_phase != PH_IDLE);
        n_rej  = (r_phase != PH_IDLE) && (i_kind != KIND_TICK);
        unique case (s_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: n_drive = 1'b1;
            PH_WR_HOLD:                       n_drive = !s_shift[0];
            default:                          n_drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= 4'd0;
            r_shift     <= 8'h00;
            r_act       <= KIND_TICK;
            r_pres      <= 1'b0;
            r_rres      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_act   <= n_act;
                r_pres  <= n_pres;
                r_rres  <= n_rres;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_drive <= n_drive;
            r_busy  <= n_busy;
            r_done  <= n_fin;
            r_rej   <= n_rej;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_low        = r_drive;
    assign o_busy_res         = r_busy;
    assign o_done_res         = r_done;
    assign o_command_rejected = r_rej;
    assign o_presence_ok      = r_pres;
    assign o_read_data        = r_rres;

    `OWM_ASSERT_NOW(a_idle_no_cmd, i_clk, i_rst_n, r_phase == PH_IDLE, r_act == KIND_TICK)
    `OWM_ASSERT_NOW(a_busy_has_cmd, i_clk, i_rst_n, r_phase != PH_IDLE, r_act != KIND_TICK)
    `OWM_ASSERT_NOW(a_bit_range, i_clk, i_rst_n, r_bit[3], r_bit[2:0] == 3'd0)
    `OWM_ASSERT_NOW(a_drive_when_busy, i_clk, i_rst_n, r_out_valid && r_drive, r_busy)
    `OWM_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_in_ready)

endmodule
